// ===== src/rqnh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqnh_pkg: shared types and constants
// Face record, register indexes and fixed widths of the nearest-hit block.
// ----------------------------------------------------------------------------
package rqnh_pkg;

	localparam int CoordW = 32;
	localparam int EdgeW  = 33;
	localparam int WideW  = 104;
	localparam int NumW   = 120;
	localparam int QDepth = 2;

	localparam logic [2:0] RegOrgX = 3'd0;
	localparam logic [2:0] RegOrgY = 3'd1;
	localparam logic [2:0] RegOrgZ = 3'd2;
	localparam logic [2:0] RegDirX = 3'd3;
	localparam logic [2:0] RegDirY = 3'd4;
	localparam logic [2:0] RegDirZ = 3'd5;

	localparam logic [31:0] TSat = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [CoordW-1:0] bx, by, bz;
		logic signed [CoordW-1:0] ux, uy, uz;
		logic signed [CoordW-1:0] vx, vy, vz;
		logic                     last;
	} face_t;

endpackage

// ===== src/rqnh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqnh_front: input stage and face queue
// Accepts faces and buffers them in a short queue for the solver.
// ----------------------------------------------------------------------------
module rqnh_front import rqnh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  face_t in_face,
	output logic  q_valid,
	input  logic  q_ready,
	output face_t q_face
);

	face_t       mem_q [QDepth];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign in_ready = (cnt_q != 2'(QDepth));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_face   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_face;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/rqnh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqnh_back: face solver
// Sequencer around a shared term multiplier, a point-step multiplier and a
// bit-serial divider; solves faces by Cramer's rule, keeps the group's nearest hit.
// ----------------------------------------------------------------------------
module rqnh_back import rqnh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [CoordW-1:0] org_x, org_y, org_z,
	input  logic signed [CoordW-1:0] dir_x, dir_y, dir_z,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  face_t                    q_face,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic signed [CoordW-1:0] distance,
	output logic signed [CoordW-1:0] cross_x, cross_y, cross_z
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_PT, S_DONE} state_t;

	state_t state_q;
	logic [6:0] bit_q;
	logic last_q;

	// Operand vectors: D, E1, E2, T and the cross products P, Q.
	logic signed [EdgeW-1:0] e1_q [3];
	logic signed [EdgeW-1:0] e2_q [3];
	logic signed [EdgeW-1:0] tv_q [3];
	logic signed [67:0]      p_q  [3];
	logic signed [67:0]      qv_q [3];
	logic signed [WideW-1:0] det_q, un_q, vn_q, tn_q, acc_q;

	logic [NumW-1:0]  num_q;
	logic [WideW:0]   rem_q;
	logic [NumW-1:0]  quo_q;
	logic [31:0]      t_q;

	logic best_v_q;
	logic [31:0] best_t_q, best_x_q, best_y_q, best_z_q;
	logic [31:0] px_q, py_q, pz_q;

	logic signed [EdgeW-1:0] dv [3];
	assign dv[0] = EdgeW'(dir_x);
	assign dv[1] = EdgeW'(dir_y);
	assign dv[2] = EdgeW'(dir_z);

	// Shared 33 by 35 bit multiplier, product registered. A cross product term
	// takes one pass; a dot term with a P or Q component takes two passes, the
	// low 34 bits of that component first and the upper bits second.
	logic [5:0]              mi;
	logic [4:0]              msel;
	logic                    mhi;
	logic signed [EdgeW-1:0] ma;
	logic signed [67:0]      mx;
	logic signed [34:0]      mb;
	logic signed [67:0]      prod;
	logic signed [67:0]      prod_q;
	logic [4:0]              msel_q;
	logic                    mhi_q;
	logic signed [WideW-1:0] term;

	// Terms 0..11: P components (two products each) then Q components;
	// 12..23: dot products det, un, vn, tn (three terms each, two passes each).
	always_comb begin
		mi = bit_q[5:0];
		if (mi < 6'd12) begin
			msel = mi[4:0];
			mhi  = 1'b0;
		end else begin
			msel = 5'(6'd12 + ((mi - 6'd12) >> 1));
			mhi  = mi[0];
		end
		ma = '0;
		mx = '0;
		case (msel)
			5'd0:  begin ma = dv[1];   mx = 68'(e2_q[2]); end
			5'd1:  begin ma = dv[2];   mx = 68'(e2_q[1]); end
			5'd2:  begin ma = dv[2];   mx = 68'(e2_q[0]); end
			5'd3:  begin ma = dv[0];   mx = 68'(e2_q[2]); end
			5'd4:  begin ma = dv[0];   mx = 68'(e2_q[1]); end
			5'd5:  begin ma = dv[1];   mx = 68'(e2_q[0]); end
			5'd6:  begin ma = tv_q[1]; mx = 68'(e1_q[2]); end
			5'd7:  begin ma = tv_q[2]; mx = 68'(e1_q[1]); end
			5'd8:  begin ma = tv_q[2]; mx = 68'(e1_q[0]); end
			5'd9:  begin ma = tv_q[0]; mx = 68'(e1_q[2]); end
			5'd10: begin ma = tv_q[0]; mx = 68'(e1_q[1]); end
			5'd11: begin ma = tv_q[1]; mx = 68'(e1_q[0]); end
			5'd12: begin ma = e1_q[0]; mx = p_q[0]; end
			5'd13: begin ma = e1_q[1]; mx = p_q[1]; end
			5'd14: begin ma = e1_q[2]; mx = p_q[2]; end
			5'd15: begin ma = tv_q[0]; mx = p_q[0]; end
			5'd16: begin ma = tv_q[1]; mx = p_q[1]; end
			5'd17: begin ma = tv_q[2]; mx = p_q[2]; end
			5'd18: begin ma = dv[0];   mx = qv_q[0]; end
			5'd19: begin ma = dv[1];   mx = qv_q[1]; end
			5'd20: begin ma = dv[2];   mx = qv_q[2]; end
			5'd21: begin ma = e2_q[0]; mx = qv_q[0]; end
			5'd22: begin ma = e2_q[1]; mx = qv_q[1]; end
			5'd23: begin ma = e2_q[2]; mx = qv_q[2]; end
			default: begin ma = '0; mx = '0; end
		endcase
		if (mhi) mb = 35'($signed(mx[66:34]));
		else if (msel < 5'd12) mb = 35'(mx);
		else mb = {1'b0, mx[33:0]};
		prod = 68'(ma * mb);
		term = mhi_q ? (WideW'(prod_q) <<< 34) : WideW'(prod_q);
	end

	// Point step: t times one direction component per cycle.
	logic signed [64:0] pt_prod;
	logic signed [64:0] pt_step;
	logic signed [65:0] pt_sum;
	logic signed [CoordW-1:0] pt_dir, pt_org;
	logic [31:0] pt_sat;
	always_comb begin
		case (bit_q[1:0])
			2'd0:    begin pt_dir = dir_x; pt_org = org_x; end
			2'd1:    begin pt_dir = dir_y; pt_org = org_y; end
			default: begin pt_dir = dir_z; pt_org = org_z; end
		endcase
		pt_prod = 65'($signed({1'b0, t_q}) * pt_dir);
		pt_step = pt_prod >>> 16;
		pt_sum  = 66'(pt_step) + 66'(pt_org);
		if (pt_sum > 66'sh7FFF_FFFF) pt_sat = 32'h7FFF_FFFF;
		else if (pt_sum < -66'sh8000_0000) pt_sat = 32'h8000_0000;
		else pt_sat = pt_sum[31:0];
	end

	logic [WideW:0] rem_sh;
	logic           rem_ge;
	assign rem_sh = {rem_q[WideW-1:0], num_q[NumW-1]};
	assign rem_ge = rem_sh >= {1'b0, det_q};

	logic signed [WideW-1:0] dn, un_n, vn_n, tn_n;
	logic hit_ok;
	always_comb begin
		dn   = det_q[WideW-1] ? -det_q : det_q;
		un_n = det_q[WideW-1] ? -un_q : un_q;
		vn_n = det_q[WideW-1] ? -vn_q : vn_q;
		tn_n = det_q[WideW-1] ? -tn_q : tn_q;
		hit_ok = (det_q != '0) && !un_n[WideW-1] && (un_n <= dn) &&
			!vn_n[WideW-1] && (vn_n <= dn) && !tn_n[WideW-1];
	end

	assign q_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		prod_q <= prod;
		msel_q <= msel;
		mhi_q  <= mhi;
		if (state_q == S_IDLE && q_valid) begin
			e1_q[0] <= EdgeW'(q_face.ux) - EdgeW'(q_face.bx);
			e1_q[1] <= EdgeW'(q_face.uy) - EdgeW'(q_face.by);
			e1_q[2] <= EdgeW'(q_face.uz) - EdgeW'(q_face.bz);
			e2_q[0] <= EdgeW'(q_face.vx) - EdgeW'(q_face.bx);
			e2_q[1] <= EdgeW'(q_face.vy) - EdgeW'(q_face.by);
			e2_q[2] <= EdgeW'(q_face.vz) - EdgeW'(q_face.bz);
			tv_q[0] <= EdgeW'(org_x) - EdgeW'(q_face.bx);
			tv_q[1] <= EdgeW'(org_y) - EdgeW'(q_face.by);
			tv_q[2] <= EdgeW'(org_z) - EdgeW'(q_face.bz);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bit_q    <= '0;
			last_q   <= 1'b0;
			best_v_q <= 1'b0;
			best_t_q <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
			best_z_q <= '0;
			out_valid <= 1'b0;
			hit <= 1'b0;
			distance <= '0;
			cross_x <= '0;
			cross_y <= '0;
			cross_z <= '0;
			acc_q <= '0;
			det_q <= '0;
			un_q <= '0;
			vn_q <= '0;
			tn_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			t_q <= '0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			for (int i = 0; i < 3; i++) begin
				p_q[i]  <= '0;
				qv_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						last_q  <= q_face.last;
						bit_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// bit_q counts issued passes; prod_q is the registered product of the previous pass.
					if (bit_q != 7'd0) begin
						case (msel_q)
							5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10: acc_q <= term;
							5'd1:  p_q[0]  <= 68'(acc_q - term);
							5'd3:  p_q[1]  <= 68'(acc_q - term);
							5'd5:  p_q[2]  <= 68'(acc_q - term);
							5'd7:  qv_q[0] <= 68'(acc_q - term);
							5'd9:  qv_q[1] <= 68'(acc_q - term);
							5'd11: qv_q[2] <= 68'(acc_q - term);
							5'd12, 5'd15, 5'd18, 5'd21:
								acc_q <= mhi_q ? acc_q + term : term;
							5'd13, 5'd16, 5'd19, 5'd22: acc_q <= acc_q + term;
							5'd14: begin
								if (mhi_q) det_q <= acc_q + term;
								else acc_q <= acc_q + term;
							end
							5'd17: begin
								if (mhi_q) un_q <= acc_q + term;
								else acc_q <= acc_q + term;
							end
							5'd20: begin
								if (mhi_q) vn_q <= acc_q + term;
								else acc_q <= acc_q + term;
							end
							5'd23: begin
								if (mhi_q) tn_q <= acc_q + term;
								else acc_q <= acc_q + term;
							end
							default: acc_q <= acc_q;
						endcase
					end
					// The dot terms read P and Q only after all their components are written.
					if (bit_q == 7'd36) begin
						state_q <= S_CHK;
					end else begin
						bit_q <= bit_q + 7'd1;
					end
				end
				S_CHK: begin
					if (hit_ok) begin
						det_q   <= dn;
						num_q   <= {tn_n, 16'd0};
						rem_q   <= '0;
						quo_q   <= '0;
						bit_q   <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_ge ? rem_sh - {1'b0, det_q} : rem_sh;
					quo_q <= {quo_q[NumW-2:0], rem_ge};
					if (bit_q == 7'(NumW - 1)) begin
						state_q <= S_PT;
						bit_q   <= '0;
					end else begin
						bit_q <= bit_q + 7'd1;
					end
				end
				S_PT: begin
					if (bit_q == 7'd0) begin
						t_q   <= (quo_q > NumW'(TSat)) ? TSat : quo_q[31:0];
						bit_q <= 7'd4;
					end else begin
						if (bit_q == 7'd4) begin
							bit_q <= 7'd1;
							state_q <= S_PT;
						end
						case (bit_q[1:0])
							2'd0: px_q <= pt_sat;
							2'd1: py_q <= pt_sat;
							default: pz_q <= pt_sat;
						endcase
						if (bit_q == 7'd2) begin
							if (!best_v_q || t_q < best_t_q) begin
								best_v_q <= 1'b1;
								best_t_q <= t_q;
								best_x_q <= px_q;
								best_y_q <= py_q;
								best_z_q <= pt_sat;
							end
							state_q <= S_DONE;
						end else if (bit_q != 7'd4) begin
							bit_q <= bit_q + 7'd1;
						end
					end
				end
				S_DONE: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						hit      <= best_v_q;
						distance <= best_t_q;
						cross_x  <= best_x_q;
						cross_y  <= best_y_q;
						cross_z  <= best_z_q;
						best_v_q <= 1'b0;
						best_t_q <= '0;
						best_x_q <= '0;
						best_y_q <= '0;
						best_z_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && out_ready && !(state_q == S_DONE && last_q)) out_valid <= 1'b0;
		end
	end

endmodule

// ===== src/ray_quad_nearest_hit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_quad_nearest_hit_top: nearest ray/parallelogram hit per face group
// Ray registers, a two-entry face queue and the solver back end.
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   cfg       cfg_we                    cfg_index, cfg_data
//   in        in_valid / in_ready       base_*, ucorner_*, vcorner_*, last_face
//   out       out_valid / out_ready     hit, distance, cross_*
//
// A face that misses goes through a step that takes it from the queue, the
// passes on the shared multiplier (twelve cross product terms, then two passes
// for each of twelve dot terms), a check and a finish step. A hit adds a
// division to a 120-bit quotient and the crossing point steps. Reset gives
// origin 0 and direction (0, 0, 1.0). The queue keeps taking faces while the
// solver works or the result waits, until both of its entries are full.
// ----------------------------------------------------------------------------
module ray_quad_nearest_hit_top import rqnh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] base_x, base_y, base_z,
	input  logic signed [31:0] ucorner_x, ucorner_y, ucorner_z,
	input  logic signed [31:0] vcorner_x, vcorner_y, vcorner_z,
	input  logic        last_face,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic signed [31:0] distance,
	output logic signed [31:0] cross_x, cross_y, cross_z
);

	logic signed [31:0] org_x_q, org_y_q, org_z_q, dir_x_q, dir_y_q, dir_z_q;
	face_t in_face, q_face;
	logic  q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			dir_z_q <= 32'sh0001_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				RegOrgX: org_x_q <= cfg_data;
				RegOrgY: org_y_q <= cfg_data;
				RegOrgZ: org_z_q <= cfg_data;
				RegDirX: dir_x_q <= cfg_data;
				RegDirY: dir_y_q <= cfg_data;
				RegDirZ: dir_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_face = '{bx: base_x, by: base_y, bz: base_z,
		ux: ucorner_x, uy: ucorner_y, uz: ucorner_z,
		vx: vcorner_x, vy: vcorner_y, vz: vcorner_z, last: last_face};

	rqnh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_face(in_face),
		.q_valid(q_valid), .q_ready(q_ready), .q_face(q_face)
	);

	rqnh_back u_back (
		.clk(clk), .arst_n(arst_n),
		.org_x(org_x_q), .org_y(org_y_q), .org_z(org_z_q),
		.dir_x(dir_x_q), .dir_y(dir_y_q), .dir_z(dir_z_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_face(q_face),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .distance(distance),
		.cross_x(cross_x), .cross_y(cross_y), .cross_z(cross_z)
	);

endmodule

// ===== tb/sv/rqnh_hit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqnh_hit_checker: scoreboard for the nearest-hit block
// Watches the register port and both channels, solves each accepted face
// with wide exact arithmetic, keeps the nearest hit of the group and checks
// every result transaction against the oldest expected group result.
// ----------------------------------------------------------------------------
module rqnh_hit_checker import rqnh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  face_t       face,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        hit,
	input  logic [31:0] distance,
	input  logic [31:0] cross_x,
	input  logic [31:0] cross_y,
	input  logic [31:0] cross_z,
	output int          errors,
	output int          pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] tval;
		logic [31:0] px, py, pz;
	} group_hit_t;

	logic [31:0] ray_org [3];
	logic [31:0] ray_dir [3];
	group_hit_t  nearest;
	group_hit_t  group_results [$];

	assign pending = group_results.size();

	function automatic wide_t sx(logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	// Crossing coordinate: origin plus floor(t * dir / 2^16), clamped to 32 bits.
	function automatic logic [31:0] cross_coord(logic [31:0] t, logic [31:0] org,
			logic [31:0] dir);
		longint prod;
		longint s;
		prod = longint'({1'b0, t}) * longint'($signed(dir));
		s = longint'($signed(org)) + (prod >>> 16);
		if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
		if (s < -64'sh8000_0000) s = -64'sh8000_0000;
		return s[31:0];
	endfunction

	// Solves one face; returns whether it is hit and its Q16.16 distance.
	function automatic logic solve_face(face_t f, output logic [31:0] tq);
		wide_t b [3], e1 [3], e2 [3], tv [3], d [3], p [3], q [3];
		wide_t det, un, vn, tn, quo;
		b[0] = sx(f.bx); b[1] = sx(f.by); b[2] = sx(f.bz);
		e1[0] = sx(f.ux) - b[0]; e1[1] = sx(f.uy) - b[1]; e1[2] = sx(f.uz) - b[2];
		e2[0] = sx(f.vx) - b[0]; e2[1] = sx(f.vy) - b[1]; e2[2] = sx(f.vz) - b[2];
		for (int i = 0; i < 3; i++) begin
			tv[i] = sx(ray_org[i]) - b[i];
			d[i] = sx(ray_dir[i]);
		end
		tq = '0;
		p[0] = d[1] * e2[2] - d[2] * e2[1];
		p[1] = d[2] * e2[0] - d[0] * e2[2];
		p[2] = d[0] * e2[1] - d[1] * e2[0];
		det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
		if (det == 0)
			return 1'b0;
		q[0] = tv[1] * e1[2] - tv[2] * e1[1];
		q[1] = tv[2] * e1[0] - tv[0] * e1[2];
		q[2] = tv[0] * e1[1] - tv[1] * e1[0];
		un = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
		vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
		tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
		if (det < 0) begin
			det = -det; un = -un; vn = -vn; tn = -tn;
		end
		if (un < 0 || un > det || vn < 0 || vn > det || tn < 0)
			return 1'b0;
		quo = (tn <<< 16) / det;
		tq = (quo > wide_t'(TSat)) ? TSat : quo[31:0];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] t;
		group_hit_t  got;
		group_hit_t  want;
		if (!arst_n) begin
			ray_org = '{32'd0, 32'd0, 32'd0};
			ray_dir = '{32'd0, 32'd0, 32'h0001_0000};
			nearest = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
			group_results.delete();
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegOrgX: ray_org[0] = cfg_data;
					RegOrgY: ray_org[1] = cfg_data;
					RegOrgZ: ray_org[2] = cfg_data;
					RegDirX: ray_dir[0] = cfg_data;
					RegDirY: ray_dir[1] = cfg_data;
					RegDirZ: ray_dir[2] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				// On a tie in distance the earlier face of the group is kept.
				if (solve_face(face, t) && (!nearest.hit || t < nearest.tval)) begin
					nearest.hit = 1'b1;
					nearest.tval = t;
					nearest.px = cross_coord(t, ray_org[0], ray_dir[0]);
					nearest.py = cross_coord(t, ray_org[1], ray_dir[1]);
					nearest.pz = cross_coord(t, ray_org[2], ray_dir[2]);
				end
				if (face.last) begin
					group_results = {group_results, nearest};
					nearest = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
				end
			end
			if (out_valid && out_ready) begin
				got = '{hit, distance, cross_x, cross_y, cross_z};
				if (group_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %b %h %h %h %h",
						$time, got.hit, got.tval, got.px, got.py, got.pz);
					errors <= errors + 1;
				end else begin
					want = group_results.pop_front();
					if (got != want) begin
						$display("%0t: result mismatch: expected %b %h %h %h %h, actual %b %h %h %h %h",
							$time, want.hit, want.tval, want.px, want.py, want.pz,
							got.hit, got.tval, got.px, got.py, got.pz);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_ray_quad_nearest_hit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_quad_nearest_hit_top: testbench of the nearest-hit block
// Directed faces (edges, parallel, degenerate, behind, saturated distance)
// and then random groups of mostly hitting faces under several
// ray settings, with random idling on both channels. A checker scores results.
// ----------------------------------------------------------------------------
module tb_ray_quad_nearest_hit_top;
	import rqnh_pkg::*;

	localparam int CycleLimit = 3000000;
	localparam int DrainCycles = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	face_t       fr;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        hit;
	logic [31:0] distance, cross_x, cross_y, cross_z;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          tx_idle_pct;
	int          rx_idle_pct;
	longint      org [3];
	longint      dir [3];

	ray_quad_nearest_hit_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.base_x(fr.bx), .base_y(fr.by), .base_z(fr.bz),
		.ucorner_x(fr.ux), .ucorner_y(fr.uy), .ucorner_z(fr.uz),
		.vcorner_x(fr.vx), .vcorner_y(fr.vy), .vcorner_z(fr.vz),
		.last_face(fr.last),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .distance(distance),
		.cross_x(cross_x), .cross_y(cross_y), .cross_z(cross_z)
	);

	rqnh_hit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .face(fr),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .distance(distance),
		.cross_x(cross_x), .cross_y(cross_y), .cross_z(cross_z),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
		if (cycles > CycleLimit) begin
			$display("tb_ray_quad_nearest_hit_top NOT OK");
			$finish;
		end
	end

	// Loads all six ray registers; the write enable drops after the last one.
	task automatic load_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz);
		logic [31:0] vals [6];
		vals = '{ox[31:0], oy[31:0], oz[31:0], dx[31:0], dy[31:0], dz[31:0]};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		org = '{longint'($signed(vals[0])), longint'($signed(vals[1])),
			longint'($signed(vals[2]))};
		dir = '{longint'($signed(vals[3])), longint'($signed(vals[4])),
			longint'($signed(vals[5]))};
		@(posedge clk);
	endtask

	task automatic send_face(face_t f);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		fr <= f;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic longint rand_edge();
		return longint'($urandom_range(1 << 19)) - (1 << 18);
	endfunction

	// Face placed so that the ray meets it at distance t (Q16.16) and face
	// coordinates a, b (Q16.16, 0..1.0 lands on the face).
	function automatic face_t face_at(longint t, longint a, longint b, logic last);
		face_t  f;
		longint p, e1, e2, bc;
		longint c [9];
		for (int i = 0; i < 3; i++) begin
			p = org[i] + ((t * dir[i]) >>> 16);
			e1 = rand_edge();
			e2 = rand_edge();
			bc = p - ((a * e1) >>> 16) - ((b * e2) >>> 16);
			c[i] = bc;
			c[3 + i] = bc + e1;
			c[6 + i] = bc + e2;
		end
		f = '{c[0][31:0], c[1][31:0], c[2][31:0], c[3][31:0], c[4][31:0],
			c[5][31:0], c[6][31:0], c[7][31:0], c[8][31:0], last};
		return f;
	endfunction

	function automatic face_t noise_face(logic last);
		face_t f;
		f = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, last};
		return f;
	endfunction

	function automatic face_t random_face(logic last);
		face_t  f;
		int     kind;
		longint a, b;
		kind = $urandom_range(99);
		a = $urandom_range(4) == 0 ? 65536 * $urandom_range(1) : $urandom_range(65536);
		b = $urandom_range(4) == 0 ? 65536 * $urandom_range(1) : $urandom_range(65536);
		if (kind < 60) begin
			f = face_at($urandom_range(64 << 16), a, b, last);
		end else if (kind < 68) begin
			f = face_at(-longint'($urandom_range(1, 16 << 16)), a, b, last);
		end else if (kind < 76) begin
			f = face_at($urandom_range(8 << 16), a + 70000, b, last);
		end else if (kind < 84) begin
			// Degenerate face: the v edge repeats the u edge.
			f = face_at($urandom_range(8 << 16), a, b, last);
			f.vx = f.ux; f.vy = f.uy; f.vz = f.uz;
		end else begin
			f = noise_face(last);
		end
		return f;
	endfunction

	initial begin
		face_t f;
		int    n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		fr = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		org = '{0, 0, 0};
		dir = '{0, 0, 65536};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset ray.
		send_face(face_at(5 << 16, 32768, 32768, 1'b1));
		send_face(face_at(3 << 16, 0, 0, 1'b0));
		send_face(face_at(2 << 16, 65536, 65536, 1'b0));
		send_face(face_at(2 << 16, 0, 65536, 1'b1));
		send_face(face_at(-(1 << 16), 32768, 32768, 1'b1));
		f = face_at(1 << 16, 32768, 32768, 1'b1);
		f.vx = f.bx; f.vy = f.by; f.vz = f.bz;
		send_face(f);
		f = face_at(1 << 16, 32768, 32768, 1'b1);
		f.uz = f.bz; f.vz = f.bz + 32'sd65536; f.vx = f.bx; f.vy = f.by;
		send_face(f);
		send_face(face_at(4 << 16, 100000, 32768, 1'b1));
		send_face(face_at(4 << 16, 32768, 32768, 1'b0));
		send_face(face_at(4 << 16, 16384, 16384, 1'b1));
		send_face('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1});
		send_face('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
			32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1});
		wait_idle();

		// Tiny direction: distances saturate.
		load_ray(0, 0, 0, 0, 0, 1);
		send_face(face_at(longint'(1) << 40, 32768, 32768, 1'b1));
		send_face(face_at(longint'(1) << 20, 32768, 32768, 1'b0));
		send_face(face_at(longint'(1) << 41, 32768, 32768, 1'b1));
		wait_idle();

		// Extreme ray: crossing points clamp.
		load_ray(32'sh7FFF_FFFF, -64'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, -64'sh8000_0000, 65536);
		send_face(face_at(1 << 16, 32768, 32768, 1'b1));
		send_face(noise_face(1'b1));
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= 3'd6;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;

		// Random part: three idling modes, several ray settings in each.
		for (int ph = 0; ph < 12; ph++) begin
			tx_idle_pct = (ph < 4) ? 7 : (ph < 8) ? 85 : 0;
			rx_idle_pct = (ph < 4) ? 85 : (ph < 8) ? 7 : 0;
			case (ph % 4)
				0: load_ray(rand_edge() * 64, rand_edge() * 64, rand_edge() * 64,
					rand_edge(), rand_edge(), rand_edge());
				1: load_ray(longint'($signed($urandom)), longint'($signed($urandom)),
					longint'($signed($urandom)), longint'($signed($urandom)),
					longint'($signed($urandom)), longint'($signed($urandom)));
				2: load_ray(-64'sh8000_0000, 32'sh7FFF_FFFF, -64'sh8000_0000,
					-64'sh8000_0000, 32'sh7FFF_FFFF, -64'sh8000_0000);
				default: load_ray(rand_edge(), rand_edge(), rand_edge(),
					$urandom_range(1, 4 << 16), rand_edge() / 4, rand_edge() / 4);
			endcase
			n = 0;
			while (n < 152) begin
				int group_len;
				group_len = $urandom_range(1, 4);
				if (ph == 9 && n >= 60 && n < 64) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				for (int k = 0; k < group_len; k++) begin
					send_face(random_face(k == group_len - 1));
					n++;
				end
			end
			wait_idle();
		end

		if (errors == 0)
			$display("tb_ray_quad_nearest_hit_top OK");
		else
			$display("tb_ray_quad_nearest_hit_top NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rqnh_pkg.sv
src/rqnh_front.sv
src/rqnh_back.sv
src/ray_quad_nearest_hit_top.sv
tb/sv/rqnh_hit_checker.sv
tb/sv/tb_ray_quad_nearest_hit_top.sv
